FILE: sv/e2q_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants, tables and types for the Euler angle to quaternion block.
// ----------------------------------------------------------------------------
package e2q_pkg;

   localparam int CORDIC_STAGES = 16;          // 8 .. 24
   localparam int LATENCY       = 4 + CORDIC_STAGES + 3;

   localparam int ANGLE_W = 16;
   localparam int QUAT_W  = 16;
   localparam int TRIG_W  = 32;                // Q30, signed
   localparam int CRD_W   = 33;                // CORDIC datapath, Q30, signed

   // pi in Q60, then pi * 2^46 split against one half turn (46080)
   localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q46   = PI_Q60 >> 14;
   localparam logic [63:0] RAD_QUO  = PI_Q46 / 64'd46080;
   localparam logic [63:0] RAD_REM  = PI_Q46 % 64'd46080;
   // floor(t / 45) = (t * RECIP45) >> 26 for t < 2^20
   localparam logic [20:0] RECIP45  = 21'd1491309;

   localparam logic signed [17:0] QUARTER_TURN = 18'sd23040;
   localparam logic signed [17:0] HALF_TURN    = 18'sd46080;

   localparam logic signed [CRD_W-1:0] GAIN_Q30 = 33'sd652032874;

   // atan(2^-i) in Q30, rounded to nearest
   localparam logic [31:0] ATAN_Q30 [24] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

   typedef struct packed {
      logic signed [TRIG_W-1:0] sin_q30;
      logic signed [TRIG_W-1:0] cos_q30;
   } trig_type;

endpackage

FILE: sv/e2q_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_lane
// One axis: half angle fold, conversion to radians, pipelined CORDIC.
// ----------------------------------------------------------------------------
module e2q_lane (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [15:0]   angle_deg,
   output e2q_pkg::trig_type    trig
);

   localparam int N = e2q_pkg::CORDIC_STAGES;
   localparam int W = e2q_pkg::CRD_W;

   // stage 0: fold into +-90 degrees of half angle
   logic signed [17:0] a_ext;
   logic signed [17:0] h_fold;
   logic               flip_in;
   logic [14:0]        mag_in;
   logic [14:0]        mag_ff;
   logic               neg_ff, flip0_ff;

   always_comb begin
      a_ext   = {{2{angle_deg[15]}}, angle_deg};
      h_fold  = a_ext;
      flip_in = 1'b0;
      priority if (a_ext > e2q_pkg::QUARTER_TURN) begin
         h_fold  = e2q_pkg::HALF_TURN - a_ext;
         flip_in = 1'b1;
      end else if (a_ext < -e2q_pkg::QUARTER_TURN) begin
         h_fold  = -e2q_pkg::HALF_TURN - a_ext;
         flip_in = 1'b1;
      end else begin
         h_fold  = a_ext;
         flip_in = 1'b0;
      end
      mag_in = h_fold[17] ? 15'(-h_fold) : h_fold[14:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff   <= mag_in;
         neg_ff   <= h_fold[17];
         flip0_ff <= flip_in;
      end
   end

   // stage 1: mag * pi / 46080 split into quotient and remainder parts
   logic [46:0] hi_ff;
   logic [30:0] lo_prod;
   logic [19:0] t_ff;
   logic        neg1_ff, flip1_ff;

   assign lo_prod = 31'(mag_ff * e2q_pkg::RAD_REM[15:0]);

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff    <= 47'(mag_ff * e2q_pkg::RAD_QUO[32:0]);
         t_ff     <= lo_prod[29:10];
         neg1_ff  <= neg_ff;
         flip1_ff <= flip0_ff;
      end
   end

   // stage 2: remainder part / 45 by reciprocal
   logic [40:0] q_prod;
   logic [47:0] sum_ff;
   logic        neg2_ff, flip2_ff;

   assign q_prod = 41'(t_ff * e2q_pkg::RECIP45);

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff   <= {1'b0, hi_ff} + {33'd0, q_prod[40:26]};
         neg2_ff  <= neg1_ff;
         flip2_ff <= flip1_ff;
      end
   end

   // stage 3: round to Q30 radians, seed CORDIC
   logic [47:0]         rnd_sum;
   logic signed [W-1:0] z_seed;

   assign rnd_sum = sum_ff + 48'd32768;
   assign z_seed  = neg2_ff ? -{2'b00, rnd_sum[46:16]} : {2'b00, rnd_sum[46:16]};

   logic signed [W-1:0] x_ff [N+1];
   logic signed [W-1:0] y_ff [N+1];
   logic signed [W-1:0] z_ff [N+1];
   logic                f_ff [N+1];

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= e2q_pkg::GAIN_Q30;
         y_ff[0] <= '0;
         z_ff[0] <= z_seed;
         f_ff[0] <= flip2_ff;
      end
   end

   // one micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic signed [W-1:0] dx, dy, ang;
      assign dx  = y_ff[i] >>> i;
      assign dy  = x_ff[i] >>> i;
      assign ang = {1'b0, e2q_pkg::ATAN_Q30[i]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][W-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - ang;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + ang;
            end
            f_ff[i+1] <= f_ff[i];
         end
      end
   end

   logic signed [W-1:0] cos_full;
   assign cos_full     = f_ff[N] ? -x_ff[N] : x_ff[N];
   assign trig.sin_q30 = y_ff[N][e2q_pkg::TRIG_W-1:0];
   assign trig.cos_q30 = cos_full[e2q_pkg::TRIG_W-1:0];

endmodule

FILE: sv/e2q_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2q_merge
// Combines the three lanes' sine and cosine into the quaternion, Q1.15.
// ----------------------------------------------------------------------------
module e2q_merge (
   input  logic                 clock,
   input  logic                 en,
   input  e2q_pkg::trig_type    tx,
   input  e2q_pkg::trig_type    ty,
   input  e2q_pkg::trig_type    tz,
   output logic signed [15:0]   quat_x,
   output logic signed [15:0]   quat_y,
   output logic signed [15:0]   quat_z,
   output logic signed [15:0]   quat_w
);

   function automatic logic signed [31:0] rnd30(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = (p + 64'sd536870912) >>> 30;
      return s[31:0];
   endfunction

   function automatic logic signed [15:0] to_q15(input logic signed [63:0] v);
      logic signed [63:0] s;
      s = (v + 64'sd17592186044416) >>> 45;
      if (s > 64'sd32767)
         return 16'sh7FFF;
      else if (s < -64'sd32768)
         return 16'sh8000;
      else
         return s[15:0];
   endfunction

   // stage 1: the four distinct x-y pair products, rounded to Q30
   logic signed [31:0] sxcy_ff, cxsy_ff, cxcy_ff, sxsy_ff;
   logic signed [31:0] sz_ff, cz_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sxcy_ff <= rnd30(64'(tx.sin_q30 * ty.cos_q30));
         cxsy_ff <= rnd30(64'(tx.cos_q30 * ty.sin_q30));
         cxcy_ff <= rnd30(64'(tx.cos_q30 * ty.cos_q30));
         sxsy_ff <= rnd30(64'(tx.sin_q30 * ty.sin_q30));
         sz_ff   <= tz.sin_q30;
         cz_ff   <= tz.cos_q30;
      end
   end

   // stage 2: products with the z terms, Q60
   logic signed [63:0] p_ff [8];

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= 64'(sxcy_ff * cz_ff);
         p_ff[1] <= 64'(cxsy_ff * sz_ff);
         p_ff[2] <= 64'(cxsy_ff * cz_ff);
         p_ff[3] <= 64'(sxcy_ff * sz_ff);
         p_ff[4] <= 64'(cxcy_ff * sz_ff);
         p_ff[5] <= 64'(sxsy_ff * cz_ff);
         p_ff[6] <= 64'(cxcy_ff * cz_ff);
         p_ff[7] <= 64'(sxsy_ff * sz_ff);
      end
   end

   // stage 3: sum, round, saturate (output register)
   always_ff @(posedge clock) begin
      if (en) begin
         quat_x <= to_q15(p_ff[0] - p_ff[1]);
         quat_y <= to_q15(p_ff[2] + p_ff[3]);
         quat_z <= to_q15(p_ff[4] - p_ff[5]);
         quat_w <= to_q15(p_ff[6] + p_ff[7]);
      end
   end

endmodule

FILE: sv/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (degrees, 7 fraction bits) to a Q1.15 unit quaternion.
// ----------------------------------------------------------------------------
// channel   dir   tdata fields (lowest bit first)
// req_      in    angle_x_deg[15:0], angle_y_deg[31:16], angle_z_deg[47:32]
// rsp_      out   quat_x[15:0], quat_y[31:16], quat_z[47:32], quat_w[63:48]
//
// Fully pipelined: one item per cycle while the result is not stalled; the stages are
// four angle-scaling stages, one per CORDIC micro-rotation, three to merge.
// The three axes run in parallel lanes; the merge stage forms the products.
// Synchronous active-high reset clears only the valid pipe.
// A stalled result freezes the whole pipe; req_tready follows from that.
// ----------------------------------------------------------------------------
module euler_to_quaternion (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // angle_x_deg, angle_y_deg, angle_z_deg
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata     // quat_x, quat_y, quat_z, quat_w
);

   localparam int LAT = e2q_pkg::LATENCY;

   logic           adv;
   logic [LAT-1:0] valid_ff, valid_in;

   // pipe moves whenever the output slot is free or being emptied
   assign adv        = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = valid_ff[LAT-1];

   always_comb begin
      valid_in = valid_ff;
      if (adv)
         valid_in = {valid_ff[LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   e2q_pkg::trig_type trig_x, trig_y, trig_z;

   e2q_lane u_lane_x (
      .clock     (clock),
      .en        (adv),
      .angle_deg (req_tdata[15:0]),
      .trig      (trig_x)
   );

   e2q_lane u_lane_y (
      .clock     (clock),
      .en        (adv),
      .angle_deg (req_tdata[31:16]),
      .trig      (trig_y)
   );

   e2q_lane u_lane_z (
      .clock     (clock),
      .en        (adv),
      .angle_deg (req_tdata[47:32]),
      .trig      (trig_z)
   );

   logic signed [15:0] quat_x, quat_y, quat_z, quat_w;

   e2q_merge u_merge (
      .clock  (clock),
      .en     (adv),
      .tx     (trig_x),
      .ty     (trig_y),
      .tz     (trig_z),
      .quat_x (quat_x),
      .quat_y (quat_y),
      .quat_z (quat_z),
      .quat_w (quat_w)
   );

   assign rsp_tdata = {quat_w, quat_z, quat_y, quat_x};

endmodule
